// ===== hw/rtl/jsesc_pkg.sv =====
// ============================================================================
// JSON string escaper package
// Shared widths, state and emission codes, ASCII constants and the hex
// digit function of the UTF-8 JSON string escaper.
// ============================================================================
package jsesc_pkg;

   localparam int ByteW    = 8;
   localparam int CharW    = 7;
   localparam int WordW    = 16;
   localparam int BufDepth = 4;
   localparam int BufIdxW  = $clog2(BufDepth);
   localparam int BufCntW  = $clog2(BufDepth + 1);
   localparam int StepW    = 3;

   localparam logic [StepW-1:0] HexLastStep = 3'd5;

   localparam logic [CharW-1:0] CH_BSLASH = 7'h5C;
   localparam logic [CharW-1:0] CH_QUOTE  = 7'h22;
   localparam logic [CharW-1:0] CH_U      = 7'h75;
   localparam logic [CharW-1:0] CH_B      = 7'h62;
   localparam logic [CharW-1:0] CH_F      = 7'h66;
   localparam logic [CharW-1:0] CH_N      = 7'h6E;
   localparam logic [CharW-1:0] CH_R      = 7'h72;
   localparam logic [CharW-1:0] CH_T      = 7'h74;

   localparam logic [ByteW-1:0] BYTE_QUOTE  = 8'h22;
   localparam logic [ByteW-1:0] BYTE_BSLASH = 8'h5C;
   localparam logic [ByteW-1:0] BYTE_BS     = 8'h08;
   localparam logic [ByteW-1:0] BYTE_FF     = 8'h0C;
   localparam logic [ByteW-1:0] BYTE_LF     = 8'h0A;
   localparam logic [ByteW-1:0] BYTE_CR     = 8'h0D;
   localparam logic [ByteW-1:0] BYTE_TAB    = 8'h09;
   localparam logic [ByteW-1:0] BYTE_SPACE  = 8'h20;
   localparam logic [ByteW-1:0] BYTE_DEL    = 8'h7F;

   localparam logic [WordW-1:0] REPLACEMENT = 16'hFFFD;
   localparam logic [WordW-1:0] SURR_HIGH   = 16'hD800;
   localparam logic [WordW-1:0] SURR_LOW    = 16'hDC00;
   localparam logic [20:0]      PLANE1_BASE = 21'h10000;
   localparam logic [20:0]      CODE_MAX    = 21'h10FFFF;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FEED   = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      EM_CHAR,
      EM_ESC,
      EM_HEX
   } emit_kind_type;

   function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 7'h30 + {3'b000, nib};
      end else begin
         return 7'h37 + {3'b000, nib};
      end
   endfunction

endpackage

// ===== hw/rtl/jsesc_req_if.sv =====
// ============================================================================
// JSON escaper request channel
// Valid/ready channel that carries one string byte and its end flag.
// ============================================================================
interface jsesc_req_if;
   import jsesc_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;
   logic             string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

// ===== hw/rtl/jsesc_rsp_if.sv =====
// ============================================================================
// JSON escaper response channel
// Valid/ready channel that carries one escaped ASCII character and flags.
// ============================================================================
interface jsesc_rsp_if;
   import jsesc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CharW-1:0] out_char;
   logic             run_last;
   logic             string_done;

   modport source (output valid, output out_char, output run_last, output string_done,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input string_done,
                   output ready);
endinterface

// ===== hw/rtl/utf8_json_string_escaper.sv =====
// ============================================================================
// UTF-8 JSON string escaper
// Takes string bytes one transaction at a time and returns the JSON-escaped
// form as ASCII characters, one character per response transaction.
// ============================================================================
// One request transaction is worked off by a small sequencer: it examines
// each byte (new, held or replayed after a rejected sequence, and each
// cut-short lead flushed at the string end), produces each output character
// from a single shift-and-hex character unit, stalling while the output
// side is full, and closes in a finish state. The request side is not
// ready while a transaction is in work; the last character waits in an
// output register, so the next request can be taken before it is consumed.
module utf8_json_string_escaper (
   input  logic        clock,
   input  logic        reset,
   jsesc_req_if.sink   req_chan,
   jsesc_rsp_if.source rsp_chan
);
   import jsesc_pkg::*;

   state_type            state_ff, state_in;
   logic [ByteW-1:0]     buf_ff [BufDepth];
   logic [ByteW-1:0]     buf_in [BufDepth];
   logic [BufCntW-1:0]   cnt_ff, cnt_in;
   logic [BufIdxW-1:0]   held_ff, held_in;
   logic [2:0]           elen_ff, elen_in;
   logic                 end_ff, end_in;
   emit_kind_type        kind_ff, kind_in;
   logic [CharW-1:0]     em_char_ff, em_char_in;
   logic [WordW-1:0]     em_word_ff, em_word_in;
   logic [WordW-1:0]     em_word2_ff, em_word2_in;
   logic                 em_pair_ff, em_pair_in;
   logic [StepW-1:0]     em_step_ff, em_step_in;
   logic                 stage_v_ff, stage_v_in;
   logic [CharW-1:0]     stage_char_ff, stage_char_in;
   logic                 out_v_ff, out_v_in;
   logic [CharW-1:0]     out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_done_ff, out_done_in;

   logic [ByteW-1:0]     cur_byte;
   logic [2:0]           held_next;
   logic                 cont1, cont2, cont3;
   logic [10:0]          cp2;
   logic [15:0]          cp3;
   logic [20:0]          cp4;
   logic [20:0]          cp4_off;
   logic                 judge_ok;
   logic                 out_free;
   logic                 gen_ok;
   logic                 gen_fire;
   logic [CharW-1:0]     gen_char;
   logic                 out_load;
   logic                 do_shift;
   logic [2:0]           shift_amt;

   assign cur_byte  = buf_ff[held_ff];
   assign held_next = {1'b0, held_ff} + 3'd1;
   assign cont1     = buf_ff[1][7:6] == 2'b10;
   assign cont2     = buf_ff[2][7:6] == 2'b10;
   assign cont3     = buf_ff[3][7:6] == 2'b10;
   assign cp2       = {buf_ff[0][4:0], buf_ff[1][5:0]};
   assign cp3       = {buf_ff[0][3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
   assign cp4       = {buf_ff[0][2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};
   assign cp4_off   = cp4 - PLANE1_BASE;

   always_comb begin
      case (elen_ff)
         3'd2:    judge_ok = cont1 && (buf_ff[0][4:1] != 4'd0);
         3'd3:    judge_ok = cont1 && cont2 && (cp3 >= 16'h0800)
                             && (cp3[15:11] != 5'b11011);
         default: judge_ok = cont1 && cont2 && cont3 && (cp4 >= PLANE1_BASE)
                             && (cp4 <= CODE_MAX);
      endcase
   end

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign gen_ok   = !stage_v_ff || out_free;

   assign req_chan.ready       = state_ff == ST_IDLE;
   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.run_last    = out_last_ff;
   assign rsp_chan.string_done = out_done_ff;

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      elen_in       = elen_ff;
      end_in        = end_ff;
      kind_in       = kind_ff;
      em_char_in    = em_char_ff;
      em_word_in    = em_word_ff;
      em_word2_in   = em_word2_ff;
      em_pair_in    = em_pair_ff;
      em_step_in    = em_step_ff;
      stage_v_in    = stage_v_ff;
      stage_char_in = stage_char_ff;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      gen_fire      = 1'b0;
      gen_char      = CH_BSLASH;
      out_load      = 1'b0;
      do_shift      = 1'b0;
      shift_amt     = 3'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               buf_in[cnt_ff[BufIdxW-1:0]] = req_chan.in_byte;
               cnt_in   = cnt_ff + 1'b1;
               end_in   = req_chan.string_end;
               state_in = ST_FEED;
            end
         end

         ST_FEED: begin
            em_step_in = '0;
            em_pair_in = 1'b0;
            if ({1'b0, held_ff} < cnt_ff) begin
               if (held_ff == '0) begin
                  do_shift = 1'b1;
                  state_in = ST_EMIT;
                  kind_in  = EM_ESC;
                  case (cur_byte)
                     BYTE_QUOTE:  em_char_in = CH_QUOTE;
                     BYTE_BSLASH: em_char_in = CH_BSLASH;
                     BYTE_BS:     em_char_in = CH_B;
                     BYTE_FF:     em_char_in = CH_F;
                     BYTE_LF:     em_char_in = CH_N;
                     BYTE_CR:     em_char_in = CH_R;
                     BYTE_TAB:    em_char_in = CH_T;
                     default: begin
                        if (cur_byte < BYTE_SPACE || cur_byte == BYTE_DEL) begin
                           kind_in    = EM_HEX;
                           em_word_in = {8'h00, cur_byte};
                        end else if (cur_byte < BYTE_DEL) begin
                           kind_in    = EM_CHAR;
                           em_char_in = cur_byte[CharW-1:0];
                        end else if (cur_byte[7:5] == 3'b110) begin
                           do_shift = 1'b0;
                           state_in = ST_FEED;
                           held_in  = 2'd1;
                           elen_in  = 3'd2;
                        end else if (cur_byte[7:4] == 4'b1110) begin
                           do_shift = 1'b0;
                           state_in = ST_FEED;
                           held_in  = 2'd1;
                           elen_in  = 3'd3;
                        end else if (cur_byte[7:3] == 5'b11110) begin
                           do_shift = 1'b0;
                           state_in = ST_FEED;
                           held_in  = 2'd1;
                           elen_in  = 3'd4;
                        end else begin
                           kind_in    = EM_HEX;
                           em_word_in = REPLACEMENT;
                        end
                     end
                  endcase
               end else if (held_next == elen_ff) begin
                  do_shift = 1'b1;
                  state_in = ST_EMIT;
                  kind_in  = EM_HEX;
                  held_in  = '0;
                  elen_in  = '0;
                  if (!judge_ok) begin
                     em_word_in = REPLACEMENT;
                  end else if (elen_ff == 3'd2) begin
                     shift_amt  = 3'd2;
                     em_word_in = {5'd0, cp2};
                  end else if (elen_ff == 3'd3) begin
                     shift_amt  = 3'd3;
                     em_word_in = cp3;
                  end else begin
                     shift_amt   = 3'd4;
                     em_word_in  = SURR_HIGH | {6'd0, cp4_off[19:10]};
                     em_word2_in = SURR_LOW | {6'd0, cp4_off[9:0]};
                     em_pair_in  = 1'b1;
                  end
               end else begin
                  held_in = held_next[BufIdxW-1:0];
               end
            end else if (end_ff && held_ff != '0) begin
               do_shift   = 1'b1;
               state_in   = ST_EMIT;
               kind_in    = EM_HEX;
               em_word_in = REPLACEMENT;
               held_in    = '0;
               elen_in    = '0;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_EMIT: begin
            if (gen_ok) begin
               gen_fire   = 1'b1;
               em_step_in = em_step_ff + 1'b1;
               case (kind_ff)
                  EM_CHAR: begin
                     gen_char = em_char_ff;
                     state_in = ST_FEED;
                  end
                  EM_ESC: begin
                     if (em_step_ff == '0) begin
                        gen_char = CH_BSLASH;
                     end else begin
                        gen_char = em_char_ff;
                        state_in = ST_FEED;
                     end
                  end
                  EM_HEX: begin
                     if (em_step_ff == '0) begin
                        gen_char = CH_BSLASH;
                     end else if (em_step_ff == 3'd1) begin
                        gen_char = CH_U;
                     end else begin
                        gen_char   = hex_char(em_word_ff[WordW-1:WordW-4]);
                        em_word_in = {em_word_ff[WordW-5:0], 4'h0};
                        if (em_step_ff == HexLastStep) begin
                           if (em_pair_ff) begin
                              em_word_in = em_word2_ff;
                              em_pair_in = 1'b0;
                              em_step_in = '0;
                           end else begin
                              state_in = ST_FEED;
                           end
                        end
                     end
                  end
                  default: begin
                     gen_char = em_char_ff;
                     state_in = ST_FEED;
                  end
               endcase
            end
         end

         ST_FINISH: begin
            if (!stage_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load    = 1'b1;
               out_char_in = stage_char_ff;
               out_last_in = 1'b1;
               out_done_in = end_ff;
               stage_v_in  = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (gen_fire) begin
         if (stage_v_ff) begin
            out_load    = 1'b1;
            out_char_in = stage_char_ff;
            out_last_in = 1'b0;
            out_done_in = 1'b0;
         end
         stage_v_in    = 1'b1;
         stage_char_in = gen_char;
      end

      if (do_shift) begin
         for (int i = 0; i < BufDepth; i++) begin
            logic [2:0] pos;
            pos = 3'(i) + shift_amt;
            if (pos < 3'(BufDepth)) begin
               buf_in[i] = buf_ff[pos[BufIdxW-1:0]];
            end
         end
         cnt_in = cnt_ff - shift_amt;
      end

      if (out_load) begin
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         held_ff    <= '0;
         elen_ff    <= '0;
         stage_v_ff <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         held_ff    <= held_in;
         elen_ff    <= elen_in;
         stage_v_ff <= stage_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff        <= buf_in;
      end_ff        <= end_in;
      kind_ff       <= kind_in;
      em_char_ff    <= em_char_in;
      em_word_ff    <= em_word_in;
      em_word2_ff   <= em_word2_in;
      em_pair_ff    <= em_pair_in;
      em_step_ff    <= em_step_in;
      stage_char_ff <= stage_char_in;
      out_char_ff   <= out_char_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   a_held_within_buffer: assert property (@(posedge clock) disable iff (reset)
      {1'b0, held_ff} <= cnt_ff)
      else $error("held bytes exceed buffered bytes");

   a_idle_stage_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !stage_v_ff)
      else $error("character left in stage at end of transaction");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.string_done) |-> rsp_chan.run_last)
      else $error("string end flagged on a character that is not last");

   a_emit_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> em_step_ff <= HexLastStep)
      else $error("emit step out of range");

endmodule
